FILE: design/ccds_pkg.sv
// shared types and constants for the charge current digipot stepper
`default_nettype none

package ccds_pkg;

  localparam int STEP_W    = 6;
  localparam int POT_W     = 20;
  localparam int CUR_W     = 12;
  localparam int DIVD_W    = 26;
  localparam int DIVS_W    = 20;
  localparam int CNT_W     = 5;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // program resistance numerator: 1000 * 1000
  localparam int PROG_SCALE = 1000000;

  localparam logic [POT_W-1:0]  POT_RESET = 20'd10000;
  localparam logic [STEP_W-1:0] MIN_RESET = 6'd0;
  localparam logic [STEP_W-1:0] MAX_RESET = 6'd63;

  localparam logic [1:0] REG_POT = 2'd0;
  localparam logic [1:0] REG_MIN = 2'd1;
  localparam logic [1:0] REG_MAX = 2'd2;

  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_NONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_MUL,
    S_DIV2,
    S_CHECK,
    S_MOVE
  } state_t;

endpackage

`default_nettype wire

FILE: design/charge_current_digipot_stepper.sv
// top level: current request to digipot wiper pulses
//
// input channel (in_valid/in_ready, target_current_ma) takes one request in
// milliamps; output channel (out_valid/out_ready) gives one transaction per
// wiper pulse: direction, new wiper_step and last on the final one, or a
// single no-move transaction when the wiper is already on target.
// the target is floor(1000000/current) scaled by (max-min) over the pot's
// full-scale resistance, plus min, clamped to max; zero current or zero
// resistance gives max.
// both divisions run on one shared restoring divider, one bit per cycle;
// the first result is registered from S_CHECK (no-move) or S_MOVE, reached
// through S_DIV1, S_MUL and S_DIV2, or straight from S_IDLE when current
// or resistance is zero; then one result per cycle for each further wiper
// step while the receiver does not stall.
// in_ready is high only while no request is in work.
// the output is a single register: a stalled receiver holds the pulse
// sequence, nothing is dropped and the wiper state follows what is shown.
// reset (rst, synchronous) loads the register defaults and puts the wiper
// at WIPER_RESET_STEP. configuration is via the apb-style port.
`default_nettype none

module charge_current_digipot_stepper #(
  parameter int WIPER_RESET_STEP = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ccds_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ccds_pkg::DATA_W-1:0]  pwdata,
  output logic      [ccds_pkg::DATA_W-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ccds_pkg::CUR_W-1:0]   target_current_ma,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [1:0]                    direction,
  output logic      [ccds_pkg::STEP_W-1:0]  wiper_step,
  output logic                               last
);

  localparam int SW = ccds_pkg::STEP_W;

  logic [ccds_pkg::POT_W-1:0] pot_ohm;
  logic [SW-1:0]              min_step;
  logic [SW-1:0]              max_step;

  ccds_pkg::state_t state, state_next;

  logic [ccds_pkg::DIVS_W-1:0] res;
  logic [SW-1:0]               tgt;
  logic [SW-1:0]               pos;
  logic [SW-1:0]               lo;
  logic [SW-1:0]               hi;
  logic [SW-1:0]               span;
  logic [SW-1:0]               tgt_next;
  logic [SW-1:0]               pos_next;
  logic                        out_free;
  logic                        emit;
  logic [1:0]                  emit_dir;
  logic                        emit_last;
  logic                        accept;
  logic                        cfg_wr;

  logic                          div_start;
  logic [ccds_pkg::DIVD_W-1:0]  div_dividend;
  logic [ccds_pkg::DIVS_W-1:0]  div_divisor;
  logic                          div_done;
  logic [ccds_pkg::DIVD_W-1:0]  div_quotient;

  ccds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pot_ohm  <= ccds_pkg::POT_RESET;
      min_step <= ccds_pkg::MIN_RESET;
      max_step <= ccds_pkg::MAX_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ccds_pkg::REG_POT: pot_ohm <= pwdata[ccds_pkg::POT_W-1:0];
        ccds_pkg::REG_MIN: min_step <= pwdata[SW-1:0];
        ccds_pkg::REG_MAX: max_step <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ccds_pkg::REG_POT: prdata = {12'd0, pot_ohm};
      ccds_pkg::REG_MIN: prdata = {26'd0, min_step};
      ccds_pkg::REG_MAX: prdata = {26'd0, max_step};
      default:           prdata = '0;
    endcase
  end

  // bounds, swapped if given the wrong way round
  always_comb begin
    lo   = (max_step < min_step) ? max_step : min_step;
    hi   = (max_step < min_step) ? min_step : max_step;
    span = hi - lo;
  end

  assign in_ready = (state == ccds_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = ccds_pkg::DIVD_W'(ccds_pkg::PROG_SCALE);
    div_divisor  = {8'd0, target_current_ma};
    tgt_next     = tgt;
    pos_next     = pos;
    emit         = 1'b0;
    emit_dir     = ccds_pkg::DIR_NONE;
    emit_last    = 1'b0;
    case (state)
      ccds_pkg::S_IDLE: begin
        if (accept) begin
          if (target_current_ma == '0 || pot_ohm == '0) begin
            tgt_next   = hi;
            state_next = ccds_pkg::S_CHECK;
          end else begin
            div_start  = 1'b1;
            state_next = ccds_pkg::S_DIV1;
          end
        end
      end
      ccds_pkg::S_DIV1: begin
        if (div_done) begin
          state_next = ccds_pkg::S_MUL;
        end
      end
      ccds_pkg::S_MUL: begin
        div_start    = 1'b1;
        div_dividend = {6'd0, res} * {20'd0, span};
        div_divisor  = pot_ohm;
        state_next   = ccds_pkg::S_DIV2;
      end
      ccds_pkg::S_DIV2: begin
        if (div_done) begin
          // q > hi - lo means q + lo overshoots hi
          tgt_next   = (div_quotient > {20'd0, span}) ? hi : div_quotient[SW-1:0] + lo;
          state_next = ccds_pkg::S_CHECK;
        end
      end
      ccds_pkg::S_CHECK: begin
        if (tgt != pos) begin
          state_next = ccds_pkg::S_MOVE;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_dir   = ccds_pkg::DIR_NONE;
          emit_last  = 1'b1;
          state_next = ccds_pkg::S_IDLE;
        end
      end
      ccds_pkg::S_MOVE: begin
        if (out_free) begin
          pos_next  = (pos < tgt) ? pos + 1'b1 : pos - 1'b1;
          emit      = 1'b1;
          emit_dir  = (pos < tgt) ? ccds_pkg::DIR_UP : ccds_pkg::DIR_DOWN;
          emit_last = (pos_next == tgt);
          if (pos_next == tgt) begin
            state_next = ccds_pkg::S_IDLE;
          end
        end
      end
      default: state_next = ccds_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccds_pkg::S_IDLE;
      pos       <= SW'(WIPER_RESET_STEP);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt <= tgt_next;
    if (state == ccds_pkg::S_DIV1 && div_done) begin
      res <= div_quotient[ccds_pkg::DIVS_W-1:0];
    end
    if (emit) begin
      direction  <= emit_dir;
      wiper_step <= pos_next;
      last       <= emit_last;
    end
  end

endmodule

`default_nettype wire

FILE: design/ccds_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module ccds_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ccds_pkg::DIVD_W-1:0] dividend,
  input  wire logic [ccds_pkg::DIVS_W-1:0] divisor,
  output logic                              done,
  output logic [ccds_pkg::DIVD_W-1:0]      quotient
);

  logic [ccds_pkg::DIVS_W-1:0] rem;
  logic [ccds_pkg::DIVD_W-1:0] quo;
  logic [ccds_pkg::DIVS_W-1:0] dvs;
  logic [ccds_pkg::CNT_W-1:0]  cnt;
  logic                        active;
  logic [ccds_pkg::DIVS_W:0]   rem_sh;
  logic                        fits;
  logic [ccds_pkg::DIVS_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem, quo[ccds_pkg::DIVD_W-1]};
    fits    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= ccds_pkg::CNT_W'(ccds_pkg::DIVD_W - 1);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (active) begin
      rem <= fits ? rem_sub[ccds_pkg::DIVS_W-1:0] : rem_sh[ccds_pkg::DIVS_W-1:0];
      quo <= {quo[ccds_pkg::DIVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

FILE: bench/ccds_checker.sv
// checker for the digipot stepper: tracks config writes, predicts wiper pulses, compares results
`timescale 1ns / 1ps

module ccds_checker #(
  parameter int WIPER_RESET_STEP = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ccds_pkg::ADDR_W-1:0] paddr,
  input  logic [ccds_pkg::DATA_W-1:0] pwdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [ccds_pkg::CUR_W-1:0]  target_current_ma,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [1:0]                  direction,
  input  logic [ccds_pkg::STEP_W-1:0] wiper_step,
  input  logic                        last,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [1:0]                  dir;
    logic [ccds_pkg::STEP_W-1:0] step;
    logic                        fin;
  } pulse_t;

  pulse_t                      expected_pulses[$];
  logic [ccds_pkg::POT_W-1:0]  pot_ohm;
  logic [ccds_pkg::STEP_W-1:0] min_reg;
  logic [ccds_pkg::STEP_W-1:0] max_reg;
  logic [ccds_pkg::STEP_W-1:0] wiper_pos;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [ccds_pkg::STEP_W-1:0] wiper_target(
    input logic [ccds_pkg::CUR_W-1:0] cur
  );
    logic [ccds_pkg::STEP_W-1:0] lo;
    logic [ccds_pkg::STEP_W-1:0] hi;
    logic [ccds_pkg::STEP_W-1:0] tmp;
    logic [63:0]                 prog_ohm;
    logic [63:0]                 t;
    lo = min_reg;
    hi = max_reg;
    if (hi < lo) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    if (cur == 0 || pot_ohm == 0) return hi;
    prog_ohm = 64'(ccds_pkg::PROG_SCALE) / 64'(cur);
    t = (prog_ohm * 64'(hi - lo)) / 64'(pot_ohm) + 64'(lo);
    if (t > 64'(hi)) t = 64'(hi);
    return t[ccds_pkg::STEP_W-1:0];
  endfunction

  task automatic predict_pulses(input logic [ccds_pkg::CUR_W-1:0] cur);
    logic [ccds_pkg::STEP_W-1:0] tgt;
    pulse_t                      p;
    tgt = wiper_target(cur);
    if (tgt == wiper_pos) begin
      p.dir  = ccds_pkg::DIR_NONE;
      p.step = wiper_pos;
      p.fin  = 1'b1;
      expected_pulses.push_back(p);
    end else begin
      while (wiper_pos != tgt) begin
        if (wiper_pos < tgt) begin
          wiper_pos = wiper_pos + 1'b1;
          p.dir     = ccds_pkg::DIR_UP;
        end else begin
          wiper_pos = wiper_pos - 1'b1;
          p.dir     = ccds_pkg::DIR_DOWN;
        end
        p.step = wiper_pos;
        p.fin  = (wiper_pos == tgt);
        expected_pulses.push_back(p);
      end
    end
  endtask

  task automatic check_pulse();
    pulse_t p;
    if (expected_pulses.size() == 0) begin
      $display("%0t: unexpected result dir %0d step %0d last %0d",
               $time, direction, wiper_step, last);
      errors++;
    end else begin
      p = expected_pulses.pop_front();
      if (direction !== p.dir) begin
        $display("%0t: direction expected %0d actual %0d", $time, p.dir, direction);
        errors++;
      end
      if (wiper_step !== p.step) begin
        $display("%0t: wiper_step expected %0d actual %0d", $time, p.step, wiper_step);
        errors++;
      end
      if (last !== p.fin) begin
        $display("%0t: last expected %0d actual %0d", $time, p.fin, last);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pot_ohm   = ccds_pkg::POT_RESET;
      min_reg   = ccds_pkg::MIN_RESET;
      max_reg   = ccds_pkg::MAX_RESET;
      wiper_pos = WIPER_RESET_STEP[ccds_pkg::STEP_W-1:0];
      expected_pulses.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          ccds_pkg::REG_POT: pot_ohm = pwdata[ccds_pkg::POT_W-1:0];
          ccds_pkg::REG_MIN: min_reg = pwdata[ccds_pkg::STEP_W-1:0];
          ccds_pkg::REG_MAX: max_reg = pwdata[ccds_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      // results of an older request are ahead in the queue, so compare first
      if (out_valid && out_ready) check_pulse();
      if (in_valid && in_ready) predict_pulses(target_current_ma);
    end
    pending = expected_pulses.size();
  end

endmodule

FILE: bench/charge_current_digipot_stepper_tb.sv
// testbench top: clock, reset, config writes, current requests, pulse stalls and verdict
`timescale 1ns / 1ps

module charge_current_digipot_stepper_tb;

  localparam int WIPER_RESET = 32;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 130;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ccds_pkg::ADDR_W-1:0] paddr = '0;
  logic [ccds_pkg::DATA_W-1:0] pwdata = '0;
  logic [ccds_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [ccds_pkg::CUR_W-1:0]  target_current_ma = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  direction;
  logic [ccds_pkg::STEP_W-1:0] wiper_step;
  logic                        last;

  int   errors;
  int   pending;
  bit   idle_on = 1'b1;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  charge_current_digipot_stepper #(
    .WIPER_RESET_STEP(WIPER_RESET)
  ) i_dut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .target_current_ma (target_current_ma),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .direction         (direction),
    .wiper_step        (wiper_step),
    .last              (last)
  );

  ccds_checker #(
    .WIPER_RESET_STEP(WIPER_RESET)
  ) i_checker (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .target_current_ma (target_current_ma),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .direction         (direction),
    .wiper_step        (wiper_step),
    .last              (last),
    .errors            (errors),
    .pending           (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls in bursts of random length
  always @(negedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready  <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("charge_current_digipot_stepper_tb failed");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [ccds_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_range(input int pot, input int lo, input int hi);
    reg_write(ccds_pkg::REG_POT, ccds_pkg::DATA_W'(pot));
    reg_write(ccds_pkg::REG_MIN, ccds_pkg::DATA_W'(lo));
    reg_write(ccds_pkg::REG_MAX, ccds_pkg::DATA_W'(hi));
  endtask

  task automatic send_current(input logic [ccds_pkg::CUR_W-1:0] cur);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid          <= 1'b1;
    target_current_ma <= cur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender off until every predicted pulse has come back
  task automatic drain_pulses();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic random_phase(input int n_items);
    logic [ccds_pkg::CUR_W-1:0] cur;
    int                         pot;
    int                         lo;
    int                         hi;
    case ($urandom_range(0, 5))
      0:       pot = 1;
      1:       pot = 1000000;
      2:       pot = $urandom_range(1, 1000000);
      default: pot = $urandom_range(200, 30000);
    endcase
    lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63);
    hi = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(0, 63);
    set_range(pot, lo, hi);
    cur = '0;
    repeat (n_items) begin
      case ($urandom_range(0, 7))
        0:       cur = '0;
        1, 2:    cur = ccds_pkg::CUR_W'($urandom_range(1, 300));
        3:       ; // same request again, usually a no-move
        default: cur = ccds_pkg::CUR_W'($urandom_range(0, 4095));
      endcase
      send_current(cur);
      if ($urandom_range(0, 15) == 0) drain_pulses();
    end
    drain_pulses();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: full sweeps up and down, a repeat, clamp edge
    send_current(12'd0);
    send_current(12'd4095);
    send_current(12'd1);
    send_current(12'd1);
    send_current(12'd159);
    send_current(12'd100);
    send_current(12'd101);
    send_current(12'd2048);
    drain_pulses();

    // bounds written the wrong way round
    set_range(10000, 63, 0);
    send_current(12'd1000);
    send_current(12'd0);
    drain_pulses();

    // zero pot resistance always targets the top step
    reg_write(ccds_pkg::REG_POT, '0);
    send_current(12'd3000);
    drain_pulses();

    set_range(1, 10, 20);
    send_current(12'd4095);
    send_current(12'd0);
    drain_pulses();

    set_range(1000000, 0, 63);
    send_current(12'd1);
    send_current(12'd2);
    send_current(12'd4095);
    drain_pulses();

    // one-step range away from the wiper
    set_range(1000000, 40, 40);
    send_current(12'd123);
    send_current(12'd0);
    drain_pulses();

    repeat (3) random_phase(20);
    idle_on = 1'b0;
    random_phase(20);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("charge_current_digipot_stepper_tb passed");
    end else begin
      $display("charge_current_digipot_stepper_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ccds_pkg.sv
design/ccds_div.sv
design/charge_current_digipot_stepper.sv
bench/ccds_checker.sv
bench/charge_current_digipot_stepper_tb.sv
